FILE: hw/rtl/imf_pkg.sv
`timescale 1ns / 1ps

package imf_pkg;

    // Geometry limits of the stores
    localparam int MAX_WIDTH    = 2048;
    localparam int MAX_HEIGHT   = 2048;
    localparam int MAX_CHANNELS = 4;
    localparam int MAX_RADIUS   = 3;

    // Fixed field and register widths
    localparam int PIX_W     = 8;
    localparam int DIM_W     = 12;
    localparam int NCH_W     = 3;
    localparam int RAD_W     = 2;
    localparam int COORD_W   = 11;
    localparam int CHAN_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH   = 12'd640;
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT  = 12'd480;
    localparam logic [NCH_W-1:0] RST_CHANNEL_COUNT = 3'd3;
    localparam logic [RAD_W-1:0] RST_WINDOW_RADIUS = 2'd1;

    // Derived sizes
    localparam int MAX_SIDE   = 2 * MAX_RADIUS + 1;
    localparam int WIN_AREA   = MAX_SIDE * MAX_SIDE;
    localparam int NUM_BANKS  = 2 * MAX_RADIUS;
    localparam int ROW_STRIDE = MAX_WIDTH * MAX_CHANNELS;
    localparam int ADDR_W     = $clog2(ROW_STRIDE);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SLOT_W     = $clog2(NUM_BANKS);
    localparam int IDX_W      = SLOT_W + 1;
    localparam int SPAN_W     = RAD_W + 1;
    localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
    localparam int CNT_W      = $clog2(WIN_AREA + 1);
    localparam int POS_MAX_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CMP_W      = ((POS_MAX_W + 1) > DIM_W) ? (POS_MAX_W + 1) : DIM_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QLVL_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [PIX_W-1:0] pix_t;
    typedef pix_t [MAX_SIDE-1:0] column_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH   = 2'd0,
        REG_IMAGE_HEIGHT  = 2'd1,
        REG_CHANNEL_COUNT = 2'd2,
        REG_WINDOW_RADIUS = 2'd3
    } cfg_index_t;

    // Clamped frame geometry
    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic [NCH_W-1:0] channels;
        logic [RAD_W-1:0] radius;
    } geom_t;

    // One new window column plus its bookkeeping, front to back
    typedef struct packed {
        column_t            column;
        logic [CH_W-1:0]    ch;
        logic [RAD_W-1:0]   radius;
        logic               emit;
        logic [COORD_W-1:0] centre_row;
        logic [COORD_W-1:0] centre_col;
    } win_entry_t;

    // Rank of the median within a (2r+1)^2 window
    function automatic logic [CNT_W-1:0] median_rank(input logic [RAD_W-1:0] r);
        logic [SIDE_W-1:0]   side;
        logic [2*SIDE_W-1:0] area;
        side = SIDE_W'({r, 1'b1});
        area = (2*SIDE_W)'(side) * (2*SIDE_W)'(side);
        return CNT_W'(area >> 1);
    endfunction

endpackage

FILE: hw/rtl/imf_front.sv
`timescale 1ns / 1ps

module imf_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  imf_pkg::geom_t                geom,
    input  logic                          s_valid,
    input  logic [imf_pkg::PIX_W-1:0]     s_pixel_value,
    output logic                          s_ready,
    input  logic [imf_pkg::QLVL_W-1:0]    queue_level,
    output logic                          push,
    output imf_pkg::win_entry_t           push_entry
);

    localparam int CMP_W  = imf_pkg::CMP_W;
    localparam int SLOT_W = imf_pkg::SLOT_W;
    localparam int IDX_W  = imf_pkg::IDX_W;

    logic [imf_pkg::COL_W-1:0] col_reg, col_next, col_c;
    logic [imf_pkg::ROW_W-1:0] row_reg, row_next, row_c;
    logic [imf_pkg::CH_W-1:0]  ch_reg, ch_next, ch_c;
    logic [SLOT_W-1:0]         mod_reg  [imf_pkg::MAX_RADIUS];
    logic [SLOT_W-1:0]         mod_next [imf_pkg::MAX_RADIUS];
    logic [SLOT_W-1:0]         mod_c    [imf_pkg::MAX_RADIUS];

    logic                       accept;
    logic                       row_rst;
    logic                       last_ch, last_col, last_row;
    logic [imf_pkg::SPAN_W-1:0] span;
    logic [SLOT_W-1:0]          slot;
    logic                       emit;
    logic [imf_pkg::ADDR_W-1:0] addr;
    logic                       wr_en;
    logic [imf_pkg::QLVL_W:0]   lvl_sum;

    logic [imf_pkg::PIX_W-1:0]  bank_rd [imf_pkg::NUM_BANKS];

    logic                        s1_valid_reg;
    logic [imf_pkg::PIX_W-1:0]   s1_pix_reg;
    logic [SLOT_W-1:0]           s1_slot_reg;
    logic [imf_pkg::SPAN_W-1:0]  s1_span_reg;
    logic [imf_pkg::RAD_W-1:0]   s1_radius_reg;
    logic [imf_pkg::CH_W-1:0]    s1_ch_reg;
    logic                        s1_emit_reg;
    logic [imf_pkg::COORD_W-1:0] s1_row_reg;
    logic [imf_pkg::COORD_W-1:0] s1_col_reg;

    // Keep room in the queue for the read that is still in flight
    assign lvl_sum = (imf_pkg::QLVL_W + 1)'(queue_level) + (imf_pkg::QLVL_W + 1)'(s1_valid_reg);
    assign s_ready = lvl_sum < (imf_pkg::QLVL_W + 1)'(imf_pkg::QUEUE_DEPTH);
    assign accept  = s_valid && s_ready;

    // Restart any position counter that lies beyond a shrunk frame
    always_comb begin
        row_rst = CMP_W'(row_reg) >= CMP_W'(geom.height);
        row_c   = row_rst ? '0 : row_reg;
        col_c   = (CMP_W'(col_reg) >= CMP_W'(geom.width)) ? '0 : col_reg;
        ch_c    = (CMP_W'(ch_reg) >= CMP_W'(geom.channels)) ? '0 : ch_reg;
        for (int j = 0; j < imf_pkg::MAX_RADIUS; j++) begin
            mod_c[j] = row_rst ? '0 : mod_reg[j];
        end
    end

    always_comb begin
        span = {geom.radius, 1'b0};
        slot = '0;
        for (int j = 0; j < imf_pkg::MAX_RADIUS; j++) begin
            if (CMP_W'(geom.radius) == CMP_W'(j + 1)) begin
                slot = mod_c[j];
            end
        end
        wr_en = (geom.radius != '0);
        emit  = (CMP_W'(row_c) >= CMP_W'(span)) && (CMP_W'(col_c) >= CMP_W'(span));
        addr  = imf_pkg::ADDR_W'(int'(col_c) * imf_pkg::MAX_CHANNELS + int'(ch_c));
    end

    always_comb begin
        last_ch  = (CMP_W'(ch_c) + CMP_W'(1)) == CMP_W'(geom.channels);
        last_col = (CMP_W'(col_c) + CMP_W'(1)) == CMP_W'(geom.width);
        last_row = (CMP_W'(row_c) + CMP_W'(1)) == CMP_W'(geom.height);
        ch_next  = ch_reg;
        col_next = col_reg;
        row_next = row_reg;
        for (int j = 0; j < imf_pkg::MAX_RADIUS; j++) begin
            mod_next[j] = mod_reg[j];
        end
        if (accept) begin
            ch_next  = last_ch ? '0 : ch_c + 1'b1;
            col_next = col_c;
            row_next = row_c;
            for (int j = 0; j < imf_pkg::MAX_RADIUS; j++) begin
                mod_next[j] = mod_c[j];
            end
            if (last_ch) begin
                col_next = last_col ? '0 : col_c + 1'b1;
                if (last_col) begin
                    row_next = last_row ? '0 : row_c + 1'b1;
                    for (int j = 0; j < imf_pkg::MAX_RADIUS; j++) begin
                        if (last_row || (mod_c[j] == SLOT_W'(2 * j + 1))) begin
                            mod_next[j] = '0;
                        end else begin
                            mod_next[j] = mod_c[j] + 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ch_reg       <= '0;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            for (int j = 0; j < imf_pkg::MAX_RADIUS; j++) begin
                mod_reg[j] <= '0;
            end
        end else begin
            ch_reg       <= ch_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= accept;
            for (int j = 0; j < imf_pkg::MAX_RADIUS; j++) begin
                mod_reg[j] <= mod_next[j];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg    <= s_pixel_value;
            s1_slot_reg   <= slot;
            s1_span_reg   <= span;
            s1_radius_reg <= geom.radius;
            s1_ch_reg     <= ch_c;
            s1_emit_reg   <= emit;
            s1_row_reg    <= imf_pkg::COORD_W'(CMP_W'(row_c) - CMP_W'(geom.radius));
            s1_col_reg    <= imf_pkg::COORD_W'(CMP_W'(col_c) - CMP_W'(geom.radius));
        end
    end

    // Line store: one bank per stored row, all read at the same address
    for (genvar b = 0; b < imf_pkg::NUM_BANKS; b++) begin : g_bank
        logic [imf_pkg::PIX_W-1:0] mem [imf_pkg::ROW_STRIDE];
        always_ff @(posedge aclk) begin
            if (accept) begin
                bank_rd[b] <= mem[addr];
                if (wr_en && (slot == SLOT_W'(b))) begin
                    mem[addr] <= s_pixel_value;
                end
            end
        end
    end

    // Rotate the banks into window order, oldest row first
    always_comb begin
        logic [IDX_W-1:0]          idx;
        logic [imf_pkg::PIX_W-1:0] col_val;
        push = s1_valid_reg;
        push_entry.ch         = s1_ch_reg;
        push_entry.radius     = s1_radius_reg;
        push_entry.emit       = s1_emit_reg;
        push_entry.centre_row = s1_row_reg;
        push_entry.centre_col = s1_col_reg;
        for (int k = 0; k < imf_pkg::MAX_SIDE; k++) begin
            idx = IDX_W'(s1_slot_reg) + IDX_W'(k);
            if (idx >= IDX_W'(s1_span_reg)) begin
                idx = idx - IDX_W'(s1_span_reg);
            end
            col_val = '0;
            for (int b = 0; b < imf_pkg::NUM_BANKS; b++) begin
                if (idx == IDX_W'(b)) begin
                    col_val = bank_rd[b];
                end
            end
            if (int'(s1_span_reg) == k) begin
                col_val = s1_pix_reg;
            end
            push_entry.column[k] = col_val;
        end
    end

endmodule

FILE: hw/rtl/imf_queue.sv
`timescale 1ns / 1ps

module imf_queue (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  imf_pkg::win_entry_t        push_entry,
    input  logic                       pop,
    output logic                       head_valid,
    output imf_pkg::win_entry_t        head_entry,
    output logic [imf_pkg::QLVL_W-1:0] level
);

    localparam int QPTR_W = imf_pkg::QPTR_W;

    imf_pkg::win_entry_t        slots [imf_pkg::QUEUE_DEPTH];
    logic [QPTR_W-1:0]          wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [imf_pkg::QLVL_W-1:0] level_reg, level_next;

    assign head_valid = (level_reg != '0);
    assign head_entry = slots[rd_ptr_reg];
    assign level      = level_reg;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(imf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(imf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            level_next = level_reg + 1'b1;
        end else if (pop && !push) begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

FILE: hw/rtl/imf_back.sv
`timescale 1ns / 1ps

module imf_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           head_valid,
    input  imf_pkg::win_entry_t            head_entry,
    output logic                           pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [imf_pkg::PIX_W-1:0]      m_median_value,
    output logic [imf_pkg::COORD_W-1:0]    m_centre_row,
    output logic [imf_pkg::COORD_W-1:0]    m_centre_column,
    output logic [imf_pkg::CHAN_W-1:0]     m_centre_channel
);

    localparam int PIX_W    = imf_pkg::PIX_W;
    localparam int MAX_SIDE = imf_pkg::MAX_SIDE;
    localparam int WIN_AREA = imf_pkg::WIN_AREA;
    localparam int CNT_W    = imf_pkg::CNT_W;

    typedef struct packed {
        imf_pkg::pix_t [WIN_AREA-1:0] vals;
        logic [WIN_AREA-1:0]          alive;
        logic [CNT_W-1:0]             rank;
        imf_pkg::pix_t                result;
        logic [imf_pkg::CH_W-1:0]     ch;
        logic [imf_pkg::COORD_W-1:0]  row;
        logic [imf_pkg::COORD_W-1:0]  col;
    } med_stage_t;

    imf_pkg::column_t win_reg [imf_pkg::MAX_CHANNELS][MAX_SIDE];
    imf_pkg::column_t win_next [MAX_SIDE];
    logic [imf_pkg::SIDE_W-1:0] side;
    logic                       pipe_en;

    med_stage_t        st_reg   [PIX_W+1];
    med_stage_t        stage_in [PIX_W+1];
    logic [PIX_W:0]    st_valid_reg;
    logic [PIX_W:0]    valid_in;

    assign pipe_en = !st_valid_reg[PIX_W] || m_ready;
    assign pop     = head_valid && pipe_en;
    assign side    = imf_pkg::SIDE_W'({head_entry.radius, 1'b1});

    // Shift this channel's window left one column and append the new one
    always_comb begin
        for (int c = 0; c < MAX_SIDE; c++) begin
            win_next[c] = win_reg[head_entry.ch][c];
        end
        for (int c = 0; c < MAX_SIDE - 1; c++) begin
            if ((c + 1) < int'(side)) begin
                win_next[c] = win_reg[head_entry.ch][c + 1];
            end
        end
        for (int c = 0; c < MAX_SIDE; c++) begin
            if (c == (int'(side) - 1)) begin
                win_next[c] = head_entry.column;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            for (int n = 0; n < imf_pkg::MAX_CHANNELS; n++) begin
                if (head_entry.ch == imf_pkg::CH_W'(n)) begin
                    for (int c = 0; c < MAX_SIDE; c++) begin
                        win_reg[n][c] <= win_next[c];
                    end
                end
            end
        end
    end

    // Load the radix-select pipeline from the updated window
    always_comb begin
        stage_in[0]        = '0;
        stage_in[0].rank   = imf_pkg::median_rank(head_entry.radius);
        stage_in[0].ch     = head_entry.ch;
        stage_in[0].row    = head_entry.centre_row;
        stage_in[0].col    = head_entry.centre_col;
        for (int c = 0; c < MAX_SIDE; c++) begin
            for (int k = 0; k < MAX_SIDE; k++) begin
                stage_in[0].vals[c * MAX_SIDE + k]  = win_next[c][k];
                stage_in[0].alive[c * MAX_SIDE + k] = (c < int'(side)) && (k < int'(side));
            end
        end
    end

    assign valid_in[0] = pop && head_entry.emit;

    // One result bit per stage, MSB first: count live zeros, pick the half
    for (genvar s = 0; s < PIX_W; s++) begin : g_stage
        localparam int BIT = PIX_W - 1 - s;
        med_stage_t nxt;
        always_comb begin
            logic [CNT_W-1:0] cnt0;
            cnt0 = '0;
            for (int i = 0; i < WIN_AREA; i++) begin
                cnt0 = cnt0 + CNT_W'(st_reg[s].alive[i] & ~st_reg[s].vals[i][BIT]);
            end
            nxt = st_reg[s];
            if (st_reg[s].rank < cnt0) begin
                nxt.result[BIT] = 1'b0;
                for (int i = 0; i < WIN_AREA; i++) begin
                    nxt.alive[i] = st_reg[s].alive[i] & ~st_reg[s].vals[i][BIT];
                end
            end else begin
                nxt.result[BIT] = 1'b1;
                nxt.rank        = st_reg[s].rank - cnt0;
                for (int i = 0; i < WIN_AREA; i++) begin
                    nxt.alive[i] = st_reg[s].alive[i] & st_reg[s].vals[i][BIT];
                end
            end
        end
        assign stage_in[s + 1] = nxt;
        assign valid_in[s + 1] = st_valid_reg[s];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= '0;
        end else if (pipe_en) begin
            st_valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int s = 0; s <= PIX_W; s++) begin
                st_reg[s] <= stage_in[s];
            end
        end
    end

    assign m_valid          = st_valid_reg[PIX_W];
    assign m_median_value   = st_reg[PIX_W].result;
    assign m_centre_row     = st_reg[PIX_W].row;
    assign m_centre_column  = st_reg[PIX_W].col;
    assign m_centre_channel = imf_pkg::CHAN_W'(st_reg[PIX_W].ch);

endmodule

FILE: hw/rtl/image_median_filter_top.sv
`timescale 1ns / 1ps

// Streaming median filter over a (2r+1)x(2r+1) window, r = 0..3, for interleaved 8-bit
// samples in raster order. One sample is accepted per clock for as long as results are
// taken; the single-ported line store banks (one bank per stored row, all read and one
// written in the same cycle) feed a four-entry queue. A result leaves once the sample
// that completes its window has passed the line store read register, the queue, and the
// window load and bit-per-stage radix select registers. Border pixels produce no result.
// The line store and window registers are not cleared after reset and need no clearing
// time; configuration writes must only happen while the block is idle.
module image_median_filter_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [imf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [imf_pkg::DIM_W-1:0]       cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [imf_pkg::PIX_W-1:0]       s_pixel_value,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [imf_pkg::PIX_W-1:0]       m_median_value,
    output logic [imf_pkg::COORD_W-1:0]     m_centre_row,
    output logic [imf_pkg::COORD_W-1:0]     m_centre_column,
    output logic [imf_pkg::CHAN_W-1:0]      m_centre_channel
);

    logic [imf_pkg::DIM_W-1:0] width_reg;
    logic [imf_pkg::DIM_W-1:0] height_reg;
    logic [imf_pkg::NCH_W-1:0] channels_reg;
    logic [imf_pkg::RAD_W-1:0] radius_reg;
    imf_pkg::geom_t            geom;

    logic                       q_push;
    imf_pkg::win_entry_t        q_push_entry;
    logic                       q_pop;
    logic                       q_head_valid;
    imf_pkg::win_entry_t        q_head_entry;
    logic [imf_pkg::QLVL_W-1:0] q_level;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= imf_pkg::RST_IMAGE_WIDTH;
            height_reg   <= imf_pkg::RST_IMAGE_HEIGHT;
            channels_reg <= imf_pkg::RST_CHANNEL_COUNT;
            radius_reg   <= imf_pkg::RST_WINDOW_RADIUS;
        end else if (cfg_wr_en) begin
            case (imf_pkg::cfg_index_t'(cfg_index))
                imf_pkg::REG_IMAGE_WIDTH: begin
                    width_reg <= cfg_wr_data;
                end
                imf_pkg::REG_IMAGE_HEIGHT: begin
                    height_reg <= cfg_wr_data;
                end
                imf_pkg::REG_CHANNEL_COUNT: begin
                    channels_reg <= cfg_wr_data[imf_pkg::NCH_W-1:0];
                end
                imf_pkg::REG_WINDOW_RADIUS: begin
                    radius_reg <= cfg_wr_data[imf_pkg::RAD_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Clamp the registers into the range the stores can hold
    always_comb begin
        if (width_reg == '0) begin
            geom.width = imf_pkg::DIM_W'(1);
        end else if (int'(width_reg) > imf_pkg::MAX_WIDTH) begin
            geom.width = imf_pkg::DIM_W'(imf_pkg::MAX_WIDTH);
        end else begin
            geom.width = width_reg;
        end
        if (height_reg == '0) begin
            geom.height = imf_pkg::DIM_W'(1);
        end else if (int'(height_reg) > imf_pkg::MAX_HEIGHT) begin
            geom.height = imf_pkg::DIM_W'(imf_pkg::MAX_HEIGHT);
        end else begin
            geom.height = height_reg;
        end
        if (channels_reg == '0) begin
            geom.channels = imf_pkg::NCH_W'(1);
        end else if (int'(channels_reg) > imf_pkg::MAX_CHANNELS) begin
            geom.channels = imf_pkg::NCH_W'(imf_pkg::MAX_CHANNELS);
        end else begin
            geom.channels = channels_reg;
        end
        if (int'(radius_reg) > imf_pkg::MAX_RADIUS) begin
            geom.radius = imf_pkg::RAD_W'(imf_pkg::MAX_RADIUS);
        end else begin
            geom.radius = radius_reg;
        end
    end

    imf_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .geom          (geom),
        .s_valid       (s_valid),
        .s_pixel_value (s_pixel_value),
        .s_ready       (s_ready),
        .queue_level   (q_level),
        .push          (q_push),
        .push_entry    (q_push_entry)
    );

    imf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head_entry),
        .level      (q_level)
    );

    imf_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .head_valid       (q_head_valid),
        .head_entry       (q_head_entry),
        .pop              (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_median_value   (m_median_value),
        .m_centre_row     (m_centre_row),
        .m_centre_column  (m_centre_column),
        .m_centre_channel (m_centre_channel)
    );

`ifndef SYNTH
    a_queue_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> ((q_level != imf_pkg::QLVL_W'(imf_pkg::QUEUE_DEPTH)) || q_pop))
        else $error("queue push while full");

    a_queue_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (q_level != '0))
        else $error("queue pop while empty");

    a_accept_reaches_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> q_push)
        else $error("accepted transaction did not reach the queue");
`endif

endmodule

FILE: test/tb_image_median_filter_top.sv
`timescale 1ns / 1ps

module tb_image_median_filter_top;
    import imf_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE      = 24;

    typedef struct {
        pix_t               median;
        logic [COORD_W-1:0] crow;
        logic [COORD_W-1:0] ccol;
        logic [CHAN_W-1:0]  cch;
    } median_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    cfg_index_t         cfg_index;
    logic [DIM_W-1:0]   cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    pix_t               s_pixel_value;
    logic               m_valid;
    logic               m_ready;
    pix_t               m_median_value;
    logic [COORD_W-1:0] m_centre_row;
    logic [COORD_W-1:0] m_centre_column;
    logic [CHAN_W-1:0]  m_centre_channel;

    image_median_filter_top uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_pixel_value    (s_pixel_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_median_value   (m_median_value),
        .m_centre_row     (m_centre_row),
        .m_centre_column  (m_centre_column),
        .m_centre_channel (m_centre_channel)
    );

    // Predictor state
    int   cur_width, cur_height, cur_chans, cur_radius;
    int   row_pos, col_pos, ch_pos;
    pix_t line_mem [0:NUM_BANKS*ROW_STRIDE-1];
    pix_t win_mem  [0:MAX_CHANNELS-1][0:MAX_SIDE-1][0:MAX_SIDE-1];

    pix_t    pixel_queue[$];
    median_t median_queue[$];
    int      errors;
    int      cycles;
    bit      in_taken;
    bit      quiet;
    bit      hold_req;
    int      tx_gap;
    int      rx_gap;
    int      hold_cnt;

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic int clamp(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    task automatic filter_sample(input pix_t v);
        int      w, h, nc, r, side, span, row, col, ch;
        pix_t    colpx[MAX_SIDE];
        pix_t    vals[$];
        median_t e;
        w = clamp(cur_width, 1, MAX_WIDTH);
        h = clamp(cur_height, 1, MAX_HEIGHT);
        nc = clamp(cur_chans, 1, MAX_CHANNELS);
        r = clamp(cur_radius, 0, MAX_RADIUS);
        side = 2 * r + 1;
        span = 2 * r;
        if (ch_pos >= nc) ch_pos = 0;
        if (col_pos >= w) col_pos = 0;
        if (row_pos >= h) row_pos = 0;
        row = row_pos;
        col = col_pos;
        ch = ch_pos;
        for (int k = 0; k < span; k++)
            colpx[k] = line_mem[((row + k) % span) * ROW_STRIDE + col * MAX_CHANNELS + ch];
        colpx[span] = v;
        if (span > 0)
            line_mem[(row % span) * ROW_STRIDE + col * MAX_CHANNELS + ch] = v;
        // shift this channel's window one column left
        for (int c = 0; c + 1 < side; c++)
            for (int k = 0; k < side; k++)
                win_mem[ch][c][k] = win_mem[ch][c+1][k];
        for (int k = 0; k < side; k++)
            win_mem[ch][side-1][k] = colpx[k];
        if (row >= span && col >= span) begin
            for (int c = 0; c < side; c++)
                for (int k = 0; k < side; k++)
                    vals.push_back(win_mem[ch][c][k]);
            vals.sort();
            e.median = vals[vals.size() / 2];
            e.crow = COORD_W'(row - r);
            e.ccol = COORD_W'(col - r);
            e.cch = CHAN_W'(ch);
            median_queue.push_back(e);
        end
        ch++;
        if (ch >= nc) begin
            ch = 0;
            col++;
            if (col >= w) begin
                col = 0;
                row++;
                if (row >= h) row = 0;
            end
        end
        ch_pos = ch;
        col_pos = col;
        row_pos = row;
    endtask

    // Input driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_valid <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
                s_pixel_value <= pixel_queue.pop_front();
                s_valid <= 1'b1;
                if (!quiet && $urandom_range(5) == 0) tx_gap = $urandom_range(1, 18);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver
    always @(negedge aclk) begin
        if (hold_cnt > 0) begin
            hold_cnt--;
            m_ready <= 1'b0;
        end else if (hold_req) begin
            hold_req = 1'b0;
            hold_cnt = HOLD_CYCLES - 1;
            m_ready <= 1'b0;
        end else if (quiet) begin
            m_ready <= 1'b1;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_ready <= 1'b0;
        end else if ($urandom_range(6) == 0) begin
            rx_gap = $urandom_range(1, 18) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Monitor: predict on accepted samples, check accepted results
    always @(posedge aclk) begin
        cycles++;
        in_taken = aresetn && s_valid && s_ready;
        if (in_taken) filter_sample(s_pixel_value);
        if (aresetn && m_valid && m_ready) begin
            if (median_queue.size() == 0) begin
                $error("unexpected result: median %0d row %0d col %0d ch %0d",
                       m_median_value, m_centre_row, m_centre_column, m_centre_channel);
                errors++;
            end else begin
                median_t e;
                e = median_queue.pop_front();
                if (m_median_value !== e.median) begin
                    $error("median_value: expected %0d, actual %0d", e.median, m_median_value);
                    errors++;
                end
                if (m_centre_row !== e.crow) begin
                    $error("centre_row: expected %0d, actual %0d", e.crow, m_centre_row);
                    errors++;
                end
                if (m_centre_column !== e.ccol) begin
                    $error("centre_column: expected %0d, actual %0d", e.ccol, m_centre_column);
                    errors++;
                end
                if (m_centre_channel !== e.cch) begin
                    $error("centre_channel: expected %0d, actual %0d", e.cch, m_centre_channel);
                    errors++;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_image_median_filter_top: errors");
            $finish;
        end
    end

    task automatic wait_drained();
        @(posedge aclk);
        while (pixel_queue.size() > 0 || s_valid || median_queue.size() > 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input int value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= DIM_W'(value);
        case (idx)
            REG_IMAGE_WIDTH:   cur_width = value;
            REG_IMAGE_HEIGHT:  cur_height = value;
            REG_CHANNEL_COUNT: cur_chans = value;
            REG_WINDOW_RADIUS: cur_radius = value;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // Drain, let the pipeline settle, then set geometry; frames always start at the origin
    task automatic set_geometry(input int w, input int h, input int nc, input int r);
        wait_drained();
        repeat (SETTLE) @(posedge aclk);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_CHANNEL_COUNT, nc);
        write_reg(REG_WINDOW_RADIUS, r);
    endtask

    function automatic pix_t gen_pixel(input int style, input int base);
        case (style)
            1: return $urandom_range(1) ? 8'hFF : 8'h00;
            2: return pix_t'(clamp(base + $urandom_range(16) - 8, 0, 255));
            default: return pix_t'($urandom_range(255));
        endcase
    endfunction

    task automatic push_samples(input int n, input int style);
        int base;
        base = $urandom_range(255);
        repeat (n) pixel_queue.push_back(gen_pixel(style, base));
    endtask

    task automatic run_frame(input int w, input int h, input int nc, input int r, input int style);
        set_geometry(w, h, nc, r);
        push_samples(w * h * nc, style);
    endtask

    int sent;

    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_wr_data = '0;
        s_valid = 1'b0;
        s_pixel_value = '0;
        m_ready = 1'b0;
        errors = 0;
        cycles = 0;
        in_taken = 1'b0;
        quiet = 1'b0;
        hold_req = 1'b0;
        tx_gap = 0;
        rx_gap = 0;
        hold_cnt = 0;
        cur_width = RST_IMAGE_WIDTH;
        cur_height = RST_IMAGE_HEIGHT;
        cur_chans = RST_CHANNEL_COUNT;
        cur_radius = RST_WINDOW_RADIUS;
        row_pos = 0;
        col_pos = 0;
        ch_pos = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Smallest frame, extreme values
        set_geometry(3, 3, 1, 1);
        pixel_queue.push_back(8'h00); pixel_queue.push_back(8'hFF); pixel_queue.push_back(8'h00);
        pixel_queue.push_back(8'hFF); pixel_queue.push_back(8'h80); pixel_queue.push_back(8'hFF);
        pixel_queue.push_back(8'h00); pixel_queue.push_back(8'hFF); pixel_queue.push_back(8'h7F);
        run_frame(5, 3, 1, 1, 0);

        // Receiver holds off while samples keep coming
        set_geometry(8, 6, 3, 1);
        hold_req = 1'b1;
        push_samples(8 * 6 * 3, 0);

        // Sender pauses mid-frame until every result is out
        set_geometry(7, 7, 2, 3);
        push_samples(50, 2);
        wait_drained();
        push_samples(7 * 7 * 2 - 50, 2);

        // Wide and tall frames, then four-channel frames
        run_frame(40, 3, 1, 1, 0);
        run_frame(3, 40, 1, 1, 1);
        run_frame(7, 7, 4, 3, 0);
        run_frame(5, 5, 4, 2, 1);

        sent = 0;
        while (sent < 800) begin
            int w, h, nc, r;
            r = $urandom_range(1, 3);
            w = $urandom_range(3, 16);
            h = $urandom_range(3, 10);
            nc = $urandom_range(1, 4);
            if ($urandom_range(4) != 0) begin
                if (w < 2 * r + 1) w = 2 * r + 1;
                if (h < 2 * r + 1) h = 2 * r + 1;
            end
            set_geometry(w, h, nc, r);
            quiet = ($urandom_range(3) == 0);
            if ($urandom_range(5) == 0) hold_req = 1'b1;
            push_samples(w * h * nc, $urandom_range(2));
            sent += w * h * nc;
        end

        // Final stretch at full rate
        set_geometry(12, 8, 3, 2);
        quiet = 1'b1;
        push_samples(12 * 8 * 3, 0);
        wait_drained();
        repeat (SETTLE) @(posedge aclk);

        if (median_queue.size() > 0) begin
            $error("%0d results never arrived", median_queue.size());
            errors++;
        end
        if (errors == 0)
            $display("tb_image_median_filter_top: clean");
        else
            $display("tb_image_median_filter_top: errors");
        $finish;
    end

endmodule
